FILE: design/assert_macros.svh
// Assertion macros used by the allocator top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared constants and types of the first-fit partition allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;
   localparam int MAX_PARTS = 32;
   localparam int ADDR_BITS = 16;
   localparam int IDX_BITS  = $clog2(MAX_PARTS);
   localparam int CNT_BITS  = $clog2(MAX_PARTS + 1);

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOFIT    = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic [15:0] MEM_SIZE_RESET = 16'd1000;

   // Update operation applied by every cell in the update cycle
   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_INIT  = 3'd1;
   localparam logic [2:0] OP_SPLIT = 3'd2;
   localparam logic [2:0] OP_FREE  = 3'd3;
   localparam logic [2:0] OP_MERGE = 3'd4;
   localparam logic [2:0] OP_TAKE  = 3'd5;   // exact fit, no shift

   typedef struct packed {
      logic [15:0]          owner;
      logic [ADDR_BITS-1:0] start;
      logic [ADDR_BITS-1:0] length;
      logic                 used;
   } entry_type;

   // Command broadcast from the controller to all cells
   typedef struct packed {
      logic [2:0]           op;
      logic [IDX_BITS-1:0]  sel;     // selected entry
      logic [IDX_BITS-1:0]  rm;      // first entry that shifts down on merge
      logic [1:0]           rm_n;    // entries removed on merge
      logic [15:0]          job;
      logic [ADDR_BITS-1:0] req;
      logic [ADDR_BITS-1:0] len;     // new length of merged entry
      logic [ADDR_BITS-1:0] mem;
   } cmd_type;
endpackage

FILE: design/first_fit_partition_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_partition_allocator_top
// First-fit partition allocator built as a row of table cells.
// ----------------------------------------------------------------------------
// Usage: raise start with req_action, req_job_id and req_request_size while
// busy is low; the item is latched at that edge. In the next cycle busy is
// high, all cells are searched and a priority pick finds the first fitting
// (allocate) or held (release) entry; the split or merge is applied at the
// end of that cycle as a shift of the cells above the selected entry.
// The result is on rsp_* with rsp_valid high in the cycle after. No new
// item is accepted while busy is high, during the search and shift cycle
// of the cell row.
// The receiver cannot stall: results must be taken when rsp_valid is high.
// csr_we with csr_wdata sets memory_size and reinitializes the table to one
// free partition in the following cycle. Reset gives memory_size 1000 and a
// single free partition; it resets the control registers but not the request and result registers.
// ----------------------------------------------------------------------------
module first_fit_partition_allocator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [15:0] req_job_id,
   input  logic [15:0] req_request_size,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_start_address,
   output logic [15:0] rsp_block_length,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);
   import ffpa_pkg::*;
   `include "assert_macros.svh"

   logic [15:0]         mem_ff;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                init_ff;
   logic                busy_ff;
   logic                act_ff;
   logic [15:0]         job_ff;
   logic [15:0]         req_ff;
   logic                vld_ff;
   logic [1:0]          st_ff;
   logic [15:0]         sa_ff, bl_ff;

   entry_type           ents [MAX_PARTS];
   logic [MAX_PARTS-1:0] fit, held;
   cmd_type             cmd;
   entry_type           zero_ent;

   assign zero_ent = '0;

   // cell row
   for (genvar g = 0; g < MAX_PARTS; g++) begin : g_cell
      ffpa_cell u_cell (
         .clock(clock), .reset(reset),
         .my_idx(IDX_BITS'(g)),
         .valid(CNT_BITS'(g) < cnt_ff),
         .prev_ent(g > 0 ? ents[(g > 0) ? g-1 : 0] : zero_ent),
         .next_ent(g + 1 < MAX_PARTS ? ents[(g+1 < MAX_PARTS) ? g+1 : g] : zero_ent),
         .next2_ent(g + 2 < MAX_PARTS ? ents[(g+2 < MAX_PARTS) ? g+2 : g] : zero_ent),
         .cmd(cmd),
         .ent(ents[g]),
         .fit(fit[g]),
         .held(held[g])
      );
   end

   // priority pick
   logic                hit;
   logic [IDX_BITS-1:0] idx;
   always_comb begin
      hit = 1'b0;
      idx = '0;
      for (int k = MAX_PARTS-1; k >= 0; k--) begin
         if (act_ff ? held[k] : fit[k]) begin
            hit = 1'b1;
            idx = IDX_BITS'(k);
         end
      end
   end

   entry_type e_sel, e_prev, e_next;
   logic prev_free, next_free;
   assign e_sel  = ents[idx];
   assign e_prev = ents[idx - 1'b1];
   assign e_next = ents[idx + 1'b1];
   assign next_free = (CNT_BITS'(idx) + 1'b1 < cnt_ff) && !e_next.used;
   assign prev_free = (idx != '0) && !e_prev.used;

   // decision for the update cycle
   logic [1:0]  st_in;
   logic [15:0] sa_in, bl_in;
   logic [ADDR_BITS-1:0] mlen;
   always_comb begin
      cmd = '0;
      cmd.job = job_ff;
      cmd.req = req_ff;
      cmd.mem = mem_ff;
      cmd.sel = idx;
      cnt_in = cnt_ff;
      st_in = ST_OK;
      sa_in = e_sel.start;
      bl_in = act_ff ? e_sel.length : req_ff;
      mlen = e_sel.length + (next_free ? e_next.length : '0);
      if (init_ff) begin
         cmd.op = OP_INIT;
         cnt_in = CNT_BITS'(1);
      end else if (busy_ff) begin
         if (job_ff == '0) st_in = ST_FULL;
         else if (!act_ff) begin
            if (req_ff == '0 || !hit) st_in = ST_NOFIT;
            else if (e_sel.length > req_ff) begin
               if (cnt_ff == CNT_BITS'(MAX_PARTS)) st_in = ST_FULL;
               else begin
                  cmd.op = OP_SPLIT;
                  cnt_in = cnt_ff + 1'b1;
               end
            end else cmd.op = OP_TAKE;
         end else begin
            if (!hit) st_in = ST_NOTFOUND;
            else if (!prev_free && !next_free) cmd.op = OP_FREE;
            else begin
               cmd.op = OP_MERGE;
               if (prev_free) begin
                  cmd.sel = idx - 1'b1;
                  cmd.len = e_prev.length + mlen;
                  cmd.rm = idx;
                  cmd.rm_n = next_free ? 2'd2 : 2'd1;
               end else begin
                  cmd.len = mlen;
                  cmd.rm = idx + 1'b1;
                  cmd.rm_n = 2'd1;
               end
               cnt_in = cnt_ff - CNT_BITS'(cmd.rm_n);
            end
         end
         if (st_in != ST_OK) begin
            sa_in = '0;
            bl_in = '0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mem_ff <= MEM_SIZE_RESET;
         cnt_ff <= CNT_BITS'(1);
         init_ff <= 1'b1;
         busy_ff <= 1'b0;
         vld_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         init_ff <= csr_we;
         if (csr_we) mem_ff <= csr_wdata;
         vld_ff <= busy_ff && !init_ff;
         busy_ff <= start && !busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         act_ff <= req_action;
         job_ff <= req_job_id;
         req_ff <= req_request_size;
      end
      st_ff <= st_in;
      sa_ff <= sa_in;
      bl_ff <= bl_in;
   end

   assign busy = busy_ff;
   assign rsp_valid = vld_ff;
   assign rsp_status = st_ff;
   assign rsp_start_address = sa_ff;
   assign rsp_block_length = bl_ff;

   `ASSERT_NEXT(a_rsp_after_busy, busy_ff && !init_ff, rsp_valid, "missing result")
   `ASSERT_IMPL(a_cnt_range, 1'b1, cnt_ff >= 1 && cnt_ff <= MAX_PARTS, "count out of range")
   `ASSERT_IMPL(a_err_zero, rsp_valid && rsp_status != ST_OK,
                rsp_start_address == '0 && rsp_block_length == '0, "error payload")
endmodule

FILE: design/ffpa_cell.sv
// ----------------------------------------------------------------------------
// ffpa_cell
// One table entry: match flags for the search, shift-based update.
// ----------------------------------------------------------------------------
module ffpa_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [ffpa_pkg::IDX_BITS-1:0] my_idx,
   input  logic                 valid,
   input  ffpa_pkg::entry_type  prev_ent,
   input  ffpa_pkg::entry_type  next_ent,
   input  ffpa_pkg::entry_type  next2_ent,
   input  ffpa_pkg::cmd_type    cmd,
   output ffpa_pkg::entry_type  ent,
   output logic                 fit,
   output logic                 held
);
   import ffpa_pkg::*;

   entry_type ent_ff, ent_in;

   // search flags
   assign fit  = valid && !ent_ff.used && ent_ff.length >= cmd.req;
   assign held = valid && ent_ff.used && ent_ff.owner == cmd.job;
   assign ent  = ent_ff;

   // update
   always_comb begin
      ent_in = ent_ff;
      unique case (cmd.op) inside
         OP_INIT: begin
            ent_in = '0;
            if (my_idx == '0) ent_in.length = cmd.mem;
         end
         OP_TAKE: begin
            if (my_idx == cmd.sel) begin
               ent_in.used = 1'b1;
               ent_in.owner = cmd.job;
            end
         end
         OP_SPLIT: begin
            if (my_idx == cmd.sel) begin
               ent_in.used = 1'b1;
               ent_in.owner = cmd.job;
               ent_in.length = cmd.req;
            end else if (my_idx == cmd.sel + 1'b1) begin
               ent_in = '0;
               ent_in.start = prev_ent.start + cmd.req;
               ent_in.length = prev_ent.length - cmd.req;
            end else if (my_idx > cmd.sel) begin
               ent_in = prev_ent;
            end
         end
         OP_FREE, OP_MERGE: begin
            if (my_idx == cmd.sel) begin
               ent_in.used = 1'b0;
               ent_in.owner = '0;
               if (cmd.op == OP_MERGE) ent_in.length = cmd.len;
            end
            if (cmd.op == OP_MERGE && my_idx >= cmd.rm) begin
               if (cmd.rm_n == 2'd2) ent_in = next2_ent;
               else ent_in = next_ent;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) ent_ff <= '0;
      else ent_ff <= ent_in;
   end
endmodule

FILE: sim/ffpa_checker.sv
// ----------------------------------------------------------------------------
// ffpa_checker
// Watches the request, response and register ports of the partition
// allocator, predicts each response from its own copy of the table and
// compares field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ffpa_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_action,
   input  logic [15:0] req_job_id,
   input  logic [15:0] req_request_size,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_status,
   input  logic [15:0] rsp_start_address,
   input  logic [15:0] rsp_block_length,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending_count,
   output int          status_seen [4]
);
   import ffpa_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] start_address;
      logic [15:0] block_length;
   } answer_type;

   // shadow table
   logic [15:0]          mem_size;
   entry_type            tbl [MAX_PARTS];
   int                   n_parts;
   answer_type           answers_due [$];

   function automatic void table_reinit();
      for (int k = 0; k < MAX_PARTS; k++) tbl[k] = '0;
      tbl[0].length = mem_size;
      n_parts = 1;
   endfunction

   function automatic void drop_entry(int i);
      for (int k = i; k + 1 < n_parts; k++) tbl[k] = tbl[k+1];
      n_parts--;
      tbl[n_parts] = '0;
   endfunction

   function automatic answer_type predict_alloc(logic [15:0] job, logic [15:0] req);
      answer_type a;
      int i;
      a = '0;
      if (req == 0) begin
         a.status = ST_NOFIT;
         return a;
      end
      for (i = 0; i < n_parts; i++)
         if (!tbl[i].used && tbl[i].length >= req) break;
      if (i >= n_parts) begin
         a.status = ST_NOFIT;
         return a;
      end
      if (tbl[i].length > req) begin
         if (n_parts >= MAX_PARTS) begin
            a.status = ST_FULL;
            return a;
         end
         for (int k = n_parts; k > i + 1; k--) tbl[k] = tbl[k-1];
         n_parts++;
         tbl[i+1].owner  = '0;
         tbl[i+1].used   = 1'b0;
         tbl[i+1].start  = tbl[i].start + req;
         tbl[i+1].length = tbl[i].length - req;
      end
      tbl[i].length = req;
      tbl[i].used   = 1'b1;
      tbl[i].owner  = job;
      a.status = ST_OK;
      a.start_address = tbl[i].start;
      a.block_length  = req;
      return a;
   endfunction

   function automatic answer_type predict_release(logic [15:0] job);
      answer_type a;
      int i;
      a = '0;
      for (i = 0; i < n_parts; i++)
         if (tbl[i].used && tbl[i].owner == job) break;
      if (i >= n_parts) begin
         a.status = ST_NOTFOUND;
         return a;
      end
      a.status = ST_OK;
      a.start_address = tbl[i].start;
      a.block_length  = tbl[i].length;
      tbl[i].used  = 1'b0;
      tbl[i].owner = '0;
      if (i + 1 < n_parts && !tbl[i+1].used) begin
         tbl[i].length += tbl[i+1].length;
         drop_entry(i + 1);
      end
      if (i > 0 && !tbl[i-1].used) begin
         tbl[i-1].length += tbl[i].length;
         drop_entry(i);
      end
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type exp_a;
      if (reset) begin
         mem_size = MEM_SIZE_RESET;
         table_reinit();
         answers_due.delete();
         fail_count = 0;
         for (int s = 0; s < 4; s++) status_seen[s] = 0;
      end else begin
         // response check
         if (rsp_valid) begin
            if (answers_due.size() == 0) begin
               $display("%0t: unexpected response st=%0d addr=%0d len=%0d", $time,
                        rsp_status, rsp_start_address, rsp_block_length);
               fail_count++;
            end else begin
               exp_a = answers_due.pop_front();
               status_seen[rsp_status]++;
               if (rsp_status !== exp_a.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           exp_a.status, rsp_status);
                  fail_count++;
               end
               if (rsp_start_address !== exp_a.start_address) begin
                  $display("%0t: start_address expected %0d actual %0d", $time,
                           exp_a.start_address, rsp_start_address);
                  fail_count++;
               end
               if (rsp_block_length !== exp_a.block_length) begin
                  $display("%0t: block_length expected %0d actual %0d", $time,
                           exp_a.block_length, rsp_block_length);
                  fail_count++;
               end
            end
         end
         // register write reinitializes the table
         if (csr_we) begin
            mem_size = csr_wdata;
            table_reinit();
         end
         // accepted request
         if (start && !busy) begin
            if (req_job_id == 0) begin
               exp_a = '0;
               exp_a.status = ST_FULL;
            end else if (req_action == 1'b0)
               exp_a = predict_alloc(req_job_id, req_request_size);
            else
               exp_a = predict_release(req_job_id);
            answers_due.push_back(exp_a);
         end
      end
      pending_count = answers_due.size();
   end
endmodule

FILE: sim/first_fit_partition_allocator_top_test.sv
// ----------------------------------------------------------------------------
// first_fit_partition_allocator_top_test
// Drives directed and random allocate/release items into the allocator,
// changes memory_size between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module first_fit_partition_allocator_top_test;
   import ffpa_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_action = 1'b0;
   logic [15:0] req_job_id = '0;
   logic [15:0] req_request_size = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_start_address;
   logic [15:0] rsp_block_length;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;
   int          fail_count;
   int          pending_count;
   int          status_seen [4];
   int          idle_cycles = 0;
   int          items_sent = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   first_fit_partition_allocator_top u_top (.*);

   ffpa_checker u_checker (.*);

   // watchdog on cycles with no accepted item or response
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", idle_cycles);
         $display("status: fail");
         $finish;
      end
   end

   // one item, random gap before it, raised once busy is low so that the
   // next rising edge accepts it
   task automatic send_item(logic act, logic [15:0] job, logic [15:0] size);
      repeat ($urandom_range(0, 3)) @(negedge clock);
      while (busy) @(negedge clock);
      start            <= 1'b1;
      req_action       <= act;
      req_job_id       <= job;
      req_request_size <= size;
      @(negedge clock);
      start <= 1'b0;
      items_sent++;
   endtask

   // write memory_size once everything has drained
   task automatic set_memory_size(logic [15:0] val);
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   // random phase: mostly allocate/release over a small job set
   task automatic random_phase(int count, int max_size, int n_jobs);
      logic [15:0] job, size;
      for (int n = 0; n < count; n++) begin
         job  = 16'($urandom_range(1, n_jobs));
         size = 16'($urandom_range(1, max_size));
         case ($urandom_range(0, 19))
            0:       job = 16'd0;
            1:       job = 16'($urandom_range(1, 16'hffff));
            2:       size = 16'($urandom_range(0, 16'hffff));
            3:       size = 16'd0;
            default: ;
         endcase
         send_item($urandom_range(0, 99) < 55 ? 1'b0 : 1'b1, job, size);
      end
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset size 1000
      send_item(1'b0, 16'd0, 16'd10);        // job id zero
      send_item(1'b1, 16'd0, 16'd0);
      send_item(1'b0, 16'd1, 16'd0);         // zero request
      send_item(1'b1, 16'd5, 16'd0);         // release of unknown job
      send_item(1'b0, 16'd1, 16'd100);
      send_item(1'b0, 16'd2, 16'd200);
      send_item(1'b0, 16'd1, 16'd50);        // duplicate id
      send_item(1'b0, 16'd3, 16'd2000);      // no fit
      send_item(1'b1, 16'd2, 16'hffff);      // free middle
      send_item(1'b1, 16'd1, 16'd0);         // lowest of the duplicates, merges
      send_item(1'b1, 16'd1, 16'd0);         // merges both sides
      send_item(1'b0, 16'hffff, 16'd1000);   // exact fit of whole memory
      send_item(1'b1, 16'hffff, 16'd0);
      // fill the table with unit splits, then split on a full table
      for (int k = 1; k <= 32; k++) send_item(1'b0, 16'(k), 16'd1);
      send_item(1'b1, 16'd5, 16'd0);
      send_item(1'b0, 16'd40, 16'd1);        // exact fit on full table

      // directed extremes of memory size
      set_memory_size(16'd0);
      send_item(1'b0, 16'd1, 16'd1);
      set_memory_size(16'hffff);
      send_item(1'b0, 16'hffff, 16'hffff);
      send_item(1'b0, 16'h8000, 16'h0001);
      send_item(1'b1, 16'hffff, 16'd0);
      send_item(1'b0, 16'h5555, 16'haaaa);
      send_item(1'b0, 16'haaaa, 16'h5555);
      send_item(1'b0, 16'h0001, 16'h8000);

      // random phases across settings
      set_memory_size(16'd1);
      random_phase(40, 2, 4);
      set_memory_size(16'd64);
      random_phase(140, 8, 40);
      set_memory_size(16'd1000);
      random_phase(140, 120, 12);
      set_memory_size(16'hffff);
      random_phase(140, 16'h3fff, 10);
      set_memory_size(16'($urandom_range(2, 16'hfffe)));
      random_phase(140, 4000, 24);

      while (pending_count != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      $display("%0d items sent: %0d ok, %0d no fit, %0d not found, %0d full or bad id",
               items_sent, status_seen[0], status_seen[1], status_seen[2],
               status_seen[3]);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

FILE: sim.f
+incdir+design
design/ffpa_pkg.sv
design/ffpa_cell.sv
design/first_fit_partition_allocator_top.sv
sim/ffpa_checker.sv
sim/first_fit_partition_allocator_top_test.sv
